### sv/assert_macros.svh
// assertion macros used by the strict priority multi fifo rtl
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### sv/spf_pkg.sv
// types and codes of the strict priority multi fifo
// no dependencies
package spf_pkg;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    localparam logic [3:0] LEVELS_RESET = 4'd8;

endpackage

### sv/spf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module spf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/strict_priority_multi_fifo.sv
// strict priority multi fifo: one fifo per level, pop from most urgent level
// a word waits in the input register, its result in the result register until out_ready takes it
// one word per cycle while out_ready keeps the result register free; the entry ram has one read or one write per word
// reset: rst_n asynchronous active low, all levels empty, levels_in_use back to 8
// depends on spf_pkg, spf_ram and assert_macros.svh
`include "assert_macros.svh"

module strict_priority_multi_fifo #(
    parameter int PRIO_LEVELS = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [2:0]  priority_req,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] out_value,
    output logic [2:0]  served_level
);

    import spf_pkg::*;

    localparam int LVL_W  = $clog2(PRIO_LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int STORE  = PRIO_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(STORE);
    localparam int CMP_W  = ($clog2(PRIO_LEVELS + 1) > 4) ? $clog2(PRIO_LEVELS + 1) : 4;

    logic [3:0]            levels_in_use_reg;
    logic                  s1_valid_reg;
    kind_t                 s1_kind_reg;
    logic [2:0]            s1_prio_reg;
    logic [31:0]           s1_value_reg;
    logic                  s2_valid_reg;
    status_t               s2_status_reg;
    logic [LVL_W-1:0]      s2_level_reg;

    logic [PTR_W-1:0]      head_reg  [PRIO_LEVELS];
    logic [PTR_W-1:0]      tail_reg  [PRIO_LEVELS];
    logic [CNT_W-1:0]      count_reg [PRIO_LEVELS];
    logic [PTR_W-1:0]      head_next [PRIO_LEVELS];
    logic [PTR_W-1:0]      tail_next [PRIO_LEVELS];
    logic [CNT_W-1:0]      count_next[PRIO_LEVELS];

    logic                  s2_free;
    logic                  s1_adv;
    logic [CMP_W-1:0]      limit;
    logic                  in_range;
    logic [LVL_W-1:0]      ins_lvl;
    logic                  lvl_full;
    logic                  found;
    logic [LVL_W-1:0]      pop_lvl;
    logic                  do_push;
    logic                  do_pop;
    status_t               status_next;
    logic [LVL_W-1:0]      level_next;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    assign s2_free  = !s2_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_in_use_reg <= LEVELS_RESET;
        end
        else if (cfg_wr_en)
        begin
            levels_in_use_reg <= cfg_wr_data;
        end
    end

    // effective level limit and insert checks
    always_comb
    begin
        if (CMP_W'(levels_in_use_reg) > CMP_W'(PRIO_LEVELS))
        begin
            limit = CMP_W'(PRIO_LEVELS);
        end
        else
        begin
            limit = CMP_W'(levels_in_use_reg);
        end
    end

    assign in_range = CMP_W'(s1_prio_reg) < limit;
    assign ins_lvl  = LVL_W'(s1_prio_reg);
    assign lvl_full = count_reg[ins_lvl] == CNT_W'(LEVEL_DEPTH);

    // lowest-numbered non-empty level in use
    always_comb
    begin
        found   = 1'b0;
        pop_lvl = '0;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0 && CMP_W'(i) < limit)
            begin
                found   = 1'b1;
                pop_lvl = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        level_next = '0;
        if (s1_kind_reg == KIND_INSERT)
        begin
            if (!in_range)
            begin
                status_next = ST_RANGE;
            end
            else if (lvl_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
            end
        end
        else if (found)
        begin
            status_next = ST_REMOVED;
            level_next  = pop_lvl;
        end
        else
        begin
            status_next = ST_EMPTY;
        end
    end

    assign do_push = s1_adv && s1_kind_reg == KIND_INSERT && in_range && !lvl_full;
    assign do_pop  = s1_adv && s1_kind_reg == KIND_REMOVE && found;

    assign wr_addr = ADDR_W'(ins_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_reg[ins_lvl]);
    assign rd_addr = ADDR_W'(pop_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_reg[pop_lvl]);

    // per level pointer and count update
    always_comb
    begin
        for (int i = 0; i < PRIO_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        if (do_push)
        begin
            if (tail_reg[ins_lvl] == PTR_W'(LEVEL_DEPTH - 1))
            begin
                tail_next[ins_lvl] = '0;
            end
            else
            begin
                tail_next[ins_lvl] = tail_reg[ins_lvl] + PTR_W'(1);
            end
            count_next[ins_lvl] = count_reg[ins_lvl] + CNT_W'(1);
        end
        if (do_pop)
        begin
            if (head_reg[pop_lvl] == PTR_W'(LEVEL_DEPTH - 1))
            begin
                head_next[pop_lvl] = '0;
            end
            else
            begin
                head_next[pop_lvl] = head_reg[pop_lvl] + PTR_W'(1);
            end
            count_next[pop_lvl] = count_reg[pop_lvl] - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRIO_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < PRIO_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_kind_reg  <= kind_t'(kind);
            s1_prio_reg  <= priority_req;
            s1_value_reg <= value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_status_reg <= status_next;
            s2_level_reg  <= level_next;
        end
    end

    spf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_addr),
        .wr_data (DATA_WIDTH'(s1_value_reg)),
        .rd_en   (do_pop),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid    = s2_valid_reg;
    assign status       = s2_status_reg;
    assign out_value    = (s2_status_reg == ST_REMOVED) ? 32'(rd_data) : '0;
    assign served_level = 3'(s2_level_reg);

    `ASSERT_IMPLIES(a_idle_fields, clk, rst_n,
        out_valid && status != ST_REMOVED,
        out_value == '0 && served_level == '0, "non-remove word carries data")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n,
        s1_adv && s2_valid_reg && !out_ready, "result overwritten while stalled")
    `ASSERT_NEVER(a_push_pop_excl, clk, rst_n, do_push && do_pop, "push and pop in one cycle")
    `ASSERT_IMPLIES(a_ready_drain, clk, rst_n,
        in_ready && s1_valid_reg, s1_adv, "input taken over a held word")

endmodule

### test/strict_priority_multi_fifo_tb.sv
// testbench for strict_priority_multi_fifo: directed and random insert/remove words
// checked against a per-level fifo scoreboard; depends on spf_pkg and the rtl
`timescale 1ns / 1ps

module strict_priority_multi_fifo_tb;

    import spf_pkg::*;

    typedef struct {
        status_t     status;
        logic [31:0] word;
        logic [2:0]  level;
    } queue_result_t;

    class priority_queue_scoreboard;
        localparam int NUM_LEVELS = 8;
        localparam int DEPTH      = 16;

        logic [31:0]   level_mem [NUM_LEVELS][DEPTH];
        int            head_slot [NUM_LEVELS];
        int            tail_slot [NUM_LEVELS];
        int            held      [NUM_LEVELS];
        logic [3:0]    levels_in_use;
        queue_result_t expected_results [$];
        int            errors;
        int            checked;
        int            status_seen [5];

        function new();
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_slot[i] = 0;
                tail_slot[i] = 0;
                held[i]      = 0;
            end
            for (int i = 0; i < 5; i++)
                status_seen[i] = 0;
            levels_in_use = LEVELS_RESET;
            errors        = 0;
            checked       = 0;
        endfunction

        function void set_levels(logic [3:0] n);
            levels_in_use = n;
        endfunction

        function int level_limit();
            return (levels_in_use > NUM_LEVELS) ? NUM_LEVELS : int'(levels_in_use);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int words_held();
            int total;
            total = 0;
            for (int i = 0; i < NUM_LEVELS; i++)
                total += held[i];
            return total;
        endfunction

        function void note_word(kind_t k, logic [2:0] prio, logic [31:0] v);
            queue_result_t res;
            int            lim;
            bit            found;
            lim       = level_limit();
            res.word  = '0;
            res.level = '0;
            found     = 1'b0;
            if (k == KIND_INSERT)
            begin
                if (int'(prio) >= lim)
                    res.status = ST_RANGE;
                else if (held[prio] >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    level_mem[prio][tail_slot[prio]] = v;
                    tail_slot[prio] = (tail_slot[prio] + 1) % DEPTH;
                    held[prio]++;
                    res.status = ST_INSERTED;
                end
            end
            else
            begin
                res.status = ST_EMPTY;
                for (int lv = 0; lv < lim; lv++)
                begin
                    if (!found && held[lv] != 0)
                    begin
                        found         = 1'b1;
                        res.status    = ST_REMOVED;
                        res.word      = level_mem[lv][head_slot[lv]];
                        res.level     = 3'(lv);
                        head_slot[lv] = (head_slot[lv] + 1) % DEPTH;
                        held[lv]--;
                    end
                end
            end
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_word(logic [2:0] st, logic [31:0] w, logic [2:0] lv);
            queue_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result word with nothing expected, status %0d", st));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
            if (w !== want.word)
                report_mismatch($sformatf("out_value %h, wanted %h", w, want.word));
            if (lv !== want.level)
                report_mismatch($sformatf("served_level %0d, wanted %0d", lv, want.level));
        endtask
    endclass

    localparam int RANDOM_ITEMS = 650;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [3:0]  cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        kind         = 1'b0;
    logic [2:0]  priority_req = '0;
    logic [31:0] value        = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [2:0]  status;
    logic [31:0] out_value;
    logic [2:0]  served_level;

    priority_queue_scoreboard sb = new();

    bit idle_on         = 1'b1;
    int long_hold_left  = 0;
    int words_sent      = 0;
    int max_held        = 0;

    strict_priority_multi_fifo #(
        .PRIO_LEVELS (8),
        .LEVEL_DEPTH (16),
        .DATA_WIDTH  (32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .priority_req (priority_req),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_value    (out_value),
        .served_level (served_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: check accepted words, random stalls, long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_word(status, out_value, served_level);
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_word(kind_t k, logic [2:0] prio, logic [31:0] v);
        in_valid     <= 1'b1;
        kind         <= k;
        priority_req <= prio;
        value        <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(k, prio, v);
        words_sent++;
        if (sb.words_held() > max_held)
            max_held = sb.words_held();
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_levels(logic [3:0] n);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_levels(n);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_level();
        int lim;
        lim = sb.level_limit();
        if (lim > 0 && $urandom_range(0, 3) != 0)
            return 3'($urandom_range(0, lim - 1));
        return 3'($urandom_range(0, 7));
    endfunction

    initial
    begin
        int         phase;
        int         phase_items;
        int         burst;
        logic [2:0] lvl;
        logic [3:0] lv_cfg;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset level count, ordering, extremes
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        send_word(KIND_INSERT, 3'd7, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 3'd3, 32'hA5A5_5A5A);
        send_word(KIND_INSERT, 3'd0, 32'h0000_0000);
        send_word(KIND_INSERT, 3'd0, 32'h1234_5678);
        send_word(KIND_REMOVE, 3'd7, 32'hFFFF_FFFF);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        send_word(KIND_REMOVE, 3'd5, 32'h0);
        send_word(KIND_INSERT, 3'd5, 32'hDEAD_BEEF);
        wait_all_results();

        // hidden levels, out of range, saturated limit
        write_levels(4'd1);
        send_word(KIND_INSERT, 3'd1, 32'h5555_5555);
        send_word(KIND_INSERT, 3'd7, 32'hAAAA_AAAA);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        send_word(KIND_INSERT, 3'd0, 32'h0F0F_0F0F);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        wait_all_results();
        write_levels(4'd15);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        wait_all_results();
        write_levels(4'd0);
        send_word(KIND_INSERT, 3'd0, 32'h8000_0001);
        send_word(KIND_REMOVE, 3'd0, 32'h0);
        wait_all_results();

        // random phases, one level setting each
        phase = 0;
        while (words_sent < RANDOM_ITEMS + 22)
        begin
            case (phase)
                0:       lv_cfg = 4'd8;
                1:       lv_cfg = 4'd1;
                2:       lv_cfg = 4'd15;
                3:       lv_cfg = 4'd0;
                default: lv_cfg = 4'($urandom_range(0, 15));
            endcase
            write_levels(lv_cfg);
            if (words_sent >= RANDOM_ITEMS - 80)
                idle_on = 1'b0;
            if (phase == 4)
                long_hold_left = 120;
            phase_items = 0;
            while (phase_items < 60)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        burst = $urandom_range(1, 18);
                        lvl   = pick_level();
                        for (int i = 0; i < burst; i++)
                            send_word(KIND_INSERT, lvl, pick_value());
                    end
                    3, 4, 5:
                    begin
                        burst = $urandom_range(1, 18);
                        for (int i = 0; i < burst; i++)
                            send_word(KIND_REMOVE, 3'($urandom_range(0, 7)), 32'($urandom));
                    end
                    default:
                    begin
                        burst = 1;
                        send_word(kind_t'($urandom_range(0, 1)), pick_level(), pick_value());
                    end
                endcase
                phase_items += burst;
                if (phase == 6 && phase_items >= 30 && phase_items - burst < 30)
                    wait_all_results();
            end
            wait_all_results();
            phase++;
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        $display("run covered %0d words in %0d phases, %0d results checked, peak %0d held",
                 words_sent, phase, sb.checked, max_held);
        $display("inserted %0d removed %0d out of range %0d empty %0d full %0d",
                 sb.status_seen[ST_INSERTED], sb.status_seen[ST_REMOVED],
                 sb.status_seen[ST_RANGE], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/spf_pkg.sv
sv/spf_ram.sv
sv/strict_priority_multi_fifo.sv
test/strict_priority_multi_fifo_tb.sv
